### design/utf8v_pkg.sv
`default_nettype none

package utf8v_pkg;

  // Pending limit on the second byte of a three- or four-byte sequence.
  typedef enum logic [2:0] {
    RULE_NONE = 3'd0,
    RULE_E0   = 3'd1,  // second byte >= A0
    RULE_ED   = 3'd2,  // second byte <  A0
    RULE_F0   = 3'd3,  // second byte >= 90
    RULE_F4   = 3'd4   // second byte <  90
  } rule_t;

  typedef struct packed {
    logic [1:0] skip_left;
    logic [1:0] bytes_owed;
    rule_t      rule;
    logic       sequence_bad;
    logic       failed;
  } state_t;

  localparam state_t STATE_RESET = '{
    skip_left:    2'd0,
    bytes_owed:   2'd0,
    rule:         RULE_NONE,
    sequence_bad: 1'b0,
    failed:       1'b0
  };

  localparam logic [1:0] SKIP_MAX = 2'd3;

endpackage

`default_nettype wire

### design/utf8v_step.sv
`default_nettype none

module utf8v_step (
  input  wire utf8v_pkg::state_t cur,
  input  wire logic [7:0]        data_byte,
  input  wire logic              buffer_start,
  input  wire logic              continued,
  input  wire logic              buffer_end,
  output utf8v_pkg::state_t      nxt,
  output logic                   valid_so_far
);
  import utf8v_pkg::*;

  function automatic logic rule_broken(rule_t rule, logic [7:0] b);
    case (rule)
      RULE_E0: rule_broken = (b < 8'hA0);
      RULE_ED: rule_broken = (b >= 8'hA0);
      RULE_F0: rule_broken = (b < 8'h90);
      RULE_F4: rule_broken = (b >= 8'h90);
      default: rule_broken = 1'b0;
    endcase
  endfunction

  logic is_cont;

  assign is_cont = (data_byte[7:6] == 2'b10);

  always_comb begin
    nxt = cur;
    if (buffer_start) begin
      nxt = STATE_RESET;
      nxt.skip_left = continued ? SKIP_MAX : 2'd0;
    end

    if (nxt.skip_left != 2'd0 && is_cont) begin
      nxt.skip_left = nxt.skip_left - 2'd1;
    end else begin
      nxt.skip_left = 2'd0;
      if (nxt.bytes_owed != 2'd0) begin
        if (!is_cont || rule_broken(nxt.rule, data_byte)) begin
          nxt.sequence_bad = 1'b1;
        end
        nxt.rule = RULE_NONE;
        nxt.bytes_owed = nxt.bytes_owed - 2'd1;
        if (nxt.bytes_owed == 2'd0) begin
          if (nxt.sequence_bad) begin
            nxt.failed = 1'b1;
          end
          nxt.sequence_bad = 1'b0;
        end
      end else if (data_byte >= 8'h80) begin
        // lead byte
        if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
          nxt.bytes_owed = 2'd1;
        end else if (data_byte[7:4] == 4'hE) begin
          nxt.bytes_owed = 2'd2;
          nxt.rule = (data_byte == 8'hE0) ? RULE_E0 :
                     (data_byte == 8'hED) ? RULE_ED : RULE_NONE;
        end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
          nxt.bytes_owed = 2'd3;
          nxt.rule = (data_byte == 8'hF0) ? RULE_F0 :
                     (data_byte == 8'hF4) ? RULE_F4 : RULE_NONE;
        end else begin
          nxt.failed = 1'b1;
        end
      end
    end

    // truncated tail is dropped, failure is kept
    if (buffer_end) begin
      nxt.bytes_owed   = 2'd0;
      nxt.rule         = RULE_NONE;
      nxt.sequence_bad = 1'b0;
      nxt.skip_left    = 2'd0;
    end
  end

  assign valid_so_far = !nxt.failed;

endmodule

`default_nettype wire

### design/utf8_stream_validator.sv
`default_nettype none

// Channel  Dir  Handshake            Payload
// -------  ---  -------------------  ------------------------------------------------
// input    in   in_valid/in_ready    data_byte[7:0], buffer_start, continued, buffer_end
// result   out  out_valid/out_ready  valid_so_far, verdict_final
//
// One byte per clock sustained while out_ready stays high; an input transaction
// reaches the result through the input register, then the result register.
// The step logic reads the input register and the tracking state; state and
// result register load together when the input register hands its byte on.
// rst (synchronous) empties both registers and clears the tracking state.
// A stalled result holds the byte behind it in the input register; in_ready
// drops only when both registers are full and out_ready is low.

module utf8_stream_validator (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       buffer_start,
  input  wire logic       continued,
  input  wire logic       buffer_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            valid_so_far,
  output logic            verdict_final
);
  import utf8v_pkg::*;

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_start;
  logic       stage_cont;
  logic       stage_end;

  // tracking state
  state_t st;
  state_t st_next;
  logic   valid_so_far_next;

  logic advance;

  // The stage moves on whenever the result register is empty or being drained.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte  <= data_byte;
      stage_start <= buffer_start;
      stage_cont  <= continued;
      stage_end   <= buffer_end;
    end
  end

  utf8v_step u_step (
    .cur          (st),
    .data_byte    (stage_byte),
    .buffer_start (stage_start),
    .continued    (stage_cont),
    .buffer_end   (stage_end),
    .nxt          (st_next),
    .valid_so_far (valid_so_far_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      valid_so_far  <= valid_so_far_next;
      verdict_final <= stage_end;
    end
  end

  // failure is sticky within a buffer, across its end too
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    advance && st.failed && !stage_start |=> st.failed)
    else $error("failed cleared without buffer_start");

  // end of buffer drops any pending sequence
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && stage_end |=> st.bytes_owed == 2'd0 && st.skip_left == 2'd0 &&
      st.rule == RULE_NONE && !st.sequence_bad)
    else $error("pending sequence survived buffer_end");

  // skipping only happens at a sequence boundary
  a_skip_no_owed: assert property (@(posedge clk) disable iff (rst)
    st.skip_left != 2'd0 |-> st.bytes_owed == 2'd0)
    else $error("skip_left set while bytes owed");

  // a second-byte rule is pending only right after a 3- or 4-byte lead
  a_rule_owed: assert property (@(posedge clk) disable iff (rst)
    st.rule != RULE_NONE |-> st.bytes_owed == 2'd2 || st.bytes_owed == 2'd3)
    else $error("second-byte rule pending without lead");

  // every staged byte yields a result carrying its buffer_end
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && verdict_final == $past(stage_end))
    else $error("result register not loaded");

endmodule

`default_nettype wire

### tb/sv/utf8_stream_validator_tb.sv
`timescale 1ns / 1ps

module utf8_stream_validator_tb;
  import utf8v_pkg::*;

  // One transaction on the byte channel, and one on the verdict channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
    logic       continued;
    logic       buffer_end;
  } byte_item_t;

  typedef struct packed {
    logic valid_so_far;
    logic verdict_final;
  } verdict_t;

  localparam int RANDOM_ITEMS   = 500;
  localparam int STALL_LIMIT    = 2000;  // cycles without any transaction
  localparam int LONG_HOLD      = 80;    // receiver back-pressure stretch
  localparam int HOLD_AFTER     = 120;   // input transactions before the long hold
  localparam int DRAIN_CYCLES   = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       buffer_start = 1'b0;
  logic       continued = 1'b0;
  logic       buffer_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       valid_so_far;
  logic       verdict_final;

  byte_item_t pending_bytes[$];
  verdict_t   expected_verdicts[$];
  logic [7:0] buf_bytes[$];      // scratch for building one buffer

  byte_item_t next_item;
  verdict_t   oldest_verdict;
  state_t     tracker = STATE_RESET;  // predictor's copy of the tracking state

  int total_items = 0;
  int in_count = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int quiet_cycles = 0;

  utf8_stream_validator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .buffer_start (buffer_start),
    .continued    (continued),
    .buffer_end   (buffer_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valid_so_far (valid_so_far),
    .verdict_final(verdict_final)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: tracks the byte stream the same way the block must.
  // ---------------------------------------------------------------------------

  function automatic bit second_byte_breaks(rule_t r, logic [7:0] b);
    case (r)
      RULE_E0: return b < 8'hA0;   // overlong three-byte form
      RULE_ED: return b >= 8'hA0;  // surrogate range
      RULE_F0: return b < 8'h90;   // overlong four-byte form
      RULE_F4: return b >= 8'h90;  // beyond U+10FFFF
      default: return 1'b0;
    endcase
  endfunction

  task automatic predict_verdict(byte_item_t it);
    bit is_cont;
    verdict_t v;
    is_cont = (it.data_byte & 8'hC0) == 8'h80;

    // Start of a buffer wipes everything; continued opens the skip window.
    if (it.buffer_start) begin
      tracker = STATE_RESET;
      tracker.skip_left = it.continued ? SKIP_MAX : 2'd0;
    end

    if (tracker.skip_left != 2'd0 && is_cont) begin
      tracker.skip_left = tracker.skip_left - 2'd1;
    end else begin
      // First non-continuation byte closes the skip window and is checked.
      tracker.skip_left = 2'd0;
      if (tracker.bytes_owed != 2'd0) begin
        if (!is_cont || second_byte_breaks(tracker.rule, it.data_byte))
          tracker.sequence_bad = 1'b1;
        tracker.rule = RULE_NONE;
        tracker.bytes_owed = tracker.bytes_owed - 2'd1;
        if (tracker.bytes_owed == 2'd0) begin
          if (tracker.sequence_bad) tracker.failed = 1'b1;
          tracker.sequence_bad = 1'b0;
        end
      end else if (it.data_byte >= 8'h80) begin
        // Lead byte decode.
        if (it.data_byte >= 8'hC2 && it.data_byte <= 8'hDF) begin
          tracker.bytes_owed = 2'd1;
        end else if ((it.data_byte & 8'hF0) == 8'hE0) begin
          tracker.bytes_owed = 2'd2;
          tracker.rule = (it.data_byte == 8'hE0) ? RULE_E0 :
                         (it.data_byte == 8'hED) ? RULE_ED : RULE_NONE;
        end else if (it.data_byte >= 8'hF0 && it.data_byte <= 8'hF4) begin
          tracker.bytes_owed = 2'd3;
          tracker.rule = (it.data_byte == 8'hF0) ? RULE_F0 :
                         (it.data_byte == 8'hF4) ? RULE_F4 : RULE_NONE;
        end else begin
          tracker.failed = 1'b1;  // stray continuation, C0/C1, F5-FF
        end
      end
    end

    // A cut-off tail is dropped along with any fault it carried.
    if (it.buffer_end) begin
      tracker.bytes_owed   = 2'd0;
      tracker.rule         = RULE_NONE;
      tracker.sequence_bad = 1'b0;
      tracker.skip_left    = 2'd0;
    end

    v.valid_so_far  = ~tracker.failed;
    v.verdict_final = it.buffer_end;
    expected_verdicts.push_back(v);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b, logic s, logic c, logic e);
    byte_item_t it;
    it.data_byte    = b;
    it.buffer_start = s;
    it.continued    = c;
    it.buffer_end   = e;
    pending_bytes.push_back(it);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Appends one well-formed character, honoring the second-byte limits.
  task automatic add_char();
    logic [7:0] lead;
    case ($urandom_range(3))
      0: buf_bytes.push_back(8'($urandom_range(127)));
      1: begin
        buf_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
        buf_bytes.push_back(cont_byte());
      end
      2: begin
        lead = 8'($urandom_range(8'hEF, 8'hE0));
        buf_bytes.push_back(lead);
        if (lead == 8'hE0) buf_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
        else if (lead == 8'hED) buf_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
        else buf_bytes.push_back(cont_byte());
        buf_bytes.push_back(cont_byte());
      end
      default: begin
        lead = 8'($urandom_range(8'hF4, 8'hF0));
        buf_bytes.push_back(lead);
        if (lead == 8'hF0) buf_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
        else if (lead == 8'hF4) buf_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
        else buf_bytes.push_back(cont_byte());
        buf_bytes.push_back(cont_byte());
        buf_bytes.push_back(cont_byte());
      end
    endcase
  endtask

  // Mostly well-formed buffers; some noise bytes, cut tails, missing
  // start (bytes after the end) and missing end markers.
  task automatic make_random_buffer();
    bit with_start;
    bit with_cont;
    bit with_end;
    with_start = ($urandom_range(7) != 0);
    with_cont  = 1'($urandom_range(1));
    with_end   = ($urandom_range(9) != 0);
    buf_bytes.delete();
    if (with_start && with_cont)
      repeat ($urandom_range(4)) buf_bytes.push_back(cont_byte());
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(9) == 0) buf_bytes.push_back(8'($urandom_range(255)));
      else add_char();
    end
    if (buf_bytes.size() > 1 && $urandom_range(4) == 0) void'(buf_bytes.pop_back());
    foreach (buf_bytes[i])
      push_byte(buf_bytes[i], with_start && i == 0, with_cont,
                with_end && i == buf_bytes.size() - 1);
  endtask

  // Idle rates: sender 33 / receiver 72, then swapped, then none.
  function automatic int send_idle_pct();
    if (in_count * 3 < total_items) return 33;
    if (in_count * 3 < total_items * 2) return 72;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (in_count * 3 < total_items) return 72;
    if (in_count * 3 < total_items * 2) return 33;
    return 0;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feeds the byte channel from pending_bytes and predicts on
  // every accepted transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_verdict('{data_byte, buffer_start, continued, buffer_end});
        in_count <= in_count + 1;
      end
      // Only move on once the current transaction is gone.
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_item = pending_bytes.pop_front();
          in_valid     <= 1'b1;
          data_byte    <= next_item.data_byte;
          buffer_start <= next_item.buffer_start;
          continued    <= next_item.continued;
          buffer_end   <= next_item.buffer_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks verdicts in order and drives out_ready, including one
  // long hold-off so the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          log_mismatch($sformatf("unexpected verdict valid_so_far=%0b verdict_final=%0b",
                                 valid_so_far, verdict_final));
        end else begin
          oldest_verdict = expected_verdicts.pop_front();
          if (valid_so_far !== oldest_verdict.valid_so_far)
            log_mismatch($sformatf("valid_so_far expected %0b got %0b",
                                   oldest_verdict.valid_so_far, valid_so_far));
          if (verdict_final !== oldest_verdict.verdict_final)
            log_mismatch($sformatf("verdict_final expected %0b got %0b",
                                   oldest_verdict.verdict_final, verdict_final));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && in_count >= HOLD_AFTER) begin
        hold_left      <= LONG_HOLD - 1;
        long_hold_done <= 1'b1;
        out_ready      <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Watchdog: too long without a transaction on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed buffers, then random ones; reset; wait for drain; verdict.
  // ---------------------------------------------------------------------------
  initial begin
    // One-byte buffer: start and end together.
    push_byte(8'h00, 1, 0, 1);
    // Well-formed mix, including the E0 and F4 edge second bytes.
    push_byte(8'h7F, 1, 0, 0);
    push_byte(8'hC2, 0, 0, 0);
    push_byte(8'h80, 0, 0, 0);
    push_byte(8'hE0, 0, 0, 0);
    push_byte(8'hA0, 0, 0, 0);
    push_byte(8'h80, 0, 0, 0);
    push_byte(8'hF4, 0, 0, 0);
    push_byte(8'h8F, 0, 0, 0);
    push_byte(8'hBF, 0, 0, 0);
    push_byte(8'hBF, 0, 0, 1);
    // Overlong E0 form: fails once the sequence completes.
    push_byte(8'hE0, 1, 0, 0);
    push_byte(8'h9F, 0, 0, 0);
    push_byte(8'h80, 0, 0, 1);
    // Truncated tail with a broken F4 limit: dropped, buffer still ok.
    push_byte(8'hF4, 1, 0, 0);
    push_byte(8'h90, 0, 0, 0);
    push_byte(8'h80, 0, 0, 1);
    // Continued buffer: three skipped, the fourth continuation is stray.
    push_byte(8'h80, 1, 1, 0);
    push_byte(8'hBF, 0, 1, 0);
    push_byte(8'h80, 0, 1, 0);
    push_byte(8'hBF, 0, 1, 1);
    // Invalid lead byte, then bytes after the end; continued without start.
    push_byte(8'hFF, 1, 0, 1);
    push_byte(8'hC2, 0, 1, 0);
    push_byte(8'h80, 0, 1, 0);

    while (pending_bytes.size() < 24 + RANDOM_ITEMS) make_random_buffer();
    total_items = pending_bytes.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### utf8_stream_validator.f
design/utf8v_pkg.sv
design/utf8v_step.sv
design/utf8_stream_validator.sv
tb/sv/utf8_stream_validator_tb.sv
